// ===== hdl/fud_pkg.sv =====
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types, character codes and helpers of the form-urlencoded decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fud_pkg;

  // Result kinds carried on the output channel.
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_NAME_END  = 2'd1;
  localparam logic [1:0] KIND_FIELD_END = 2'd2;

  // Characters with a special meaning in the encoding.
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Most results one request can produce.
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  // Escape sequencer states.
  typedef enum logic [2:0] {
    ESC_IDLE    = 3'b001,
    ESC_PERCENT = 3'b010,
    ESC_DIGIT   = 3'b100
  } esc_e;

  // One result request.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       in_value;
    logic       last;
  } res_t;

  // Hex digit value; bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b0, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r = {1'b0, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic res_t mk_res(input logic [7:0] d, input logic [1:0] k,
                                  input logic v, input logic l);
    res_t r;
    r.data     = d;
    r.kind     = k;
    r.in_value = v;
    r.last     = l;
    return r;
  endfunction

endpackage

// ===== hdl/fud_in_if.sv =====
// ----------------------------------------------------------------------------
// fud_in_if
// Input channel of the decoder: one raw encoded byte per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

// ===== hdl/fud_out_if.sv =====
// ----------------------------------------------------------------------------
// fud_out_if
// Output channel of the decoder: one decoded byte or marker per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       in_value;
  logic       out_last;

  modport source (output valid, out_byte, kind, in_value, out_last, input ready);
  modport sink   (input valid, out_byte, kind, in_value, out_last, output ready);
endinterface

// ===== hdl/form_urlencoded_decoder.sv =====
// ----------------------------------------------------------------------------
// form_urlencoded_decoder
// Streaming decoder for form-urlencoded text with name/value tagging.
// ----------------------------------------------------------------------------
// The decoder takes one encoded byte per cycle while the output keeps up, and
// returns decoded bytes tagged as name or value, plus markers for the end of
// a name and the end of a field. A byte is registered on entry, decoded in
// one pass into between zero and three results, and those results are loaded
// into a three-entry result bank that drives the output channel, so a result
// passes the input register and then the bank register. A byte yielding one
// result sustains one byte per cycle while the output accepts; a byte yielding
// k results occupies the single output port until all k are taken, and the
// input holds off until the bank is down to its last entry. Bytes yielding no
// result (an opening percent sign, a first escape digit) leave the bank empty.
`timescale 1ns / 1ps

module form_urlencoded_decoder (
  input  logic  clk_i,
  input  logic  rst_ni,
  fud_in_if.sink    in_chan_i,
  fud_out_if.source out_chan_o
);
  import fud_pkg::*;

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Decoder state.
  esc_e       esc_q, esc_d;
  logic [3:0] digit_q, digit_d;
  logic       role_q, role_d;

  // Result bank, entry 0 faces the output.
  res_t            bank_q [MaxResults];
  logic [CntW-1:0] cnt_q;

  res_t            res [MaxResults];
  logic [CntW-1:0] n;
  logic            bank_free, proc, in_fire, out_fire;
  logic [4:0]      hv;
  logic            is_hex, taken;

  // Handshakes: the bank can take a new set when empty or on its last drain.
  assign out_fire  = out_chan_o.valid && out_chan_o.ready;
  assign bank_free = (cnt_q == '0) || (cnt_q == CntW'(1) && out_chan_o.ready);
  assign proc      = in_vld_q && bank_free;
  assign in_chan_i.ready = !in_vld_q || proc;
  assign in_fire   = in_chan_i.valid && in_chan_i.ready;

  assign hv     = hex_of(in_byte_q);
  assign is_hex = !hv[4];

  // Single-pass decode of the registered byte.
  always_comb begin
    esc_d   = ESC_IDLE;
    digit_d = digit_q;
    role_d  = role_q;
    taken   = 1'b0;
    n       = '0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = mk_res(8'h00, KIND_DATA, 1'b0, 1'b0);
    end

    // Finish or abandon an open escape.
    unique case (esc_q)
      ESC_PERCENT: begin
        if (is_hex) begin
          digit_d = hv[3:0];
          esc_d   = ESC_DIGIT;
          taken   = 1'b1;
        end else begin
          res[n] = mk_res(CHAR_PERCENT, KIND_DATA, role_q, 1'b0);
          n      = n + CntW'(1);
        end
      end
      ESC_DIGIT: begin
        if (is_hex) begin
          res[n] = mk_res({digit_q, hv[3:0]}, KIND_DATA, role_q, 1'b0);
          taken  = 1'b1;
        end else begin
          res[n] = mk_res({4'h0, digit_q}, KIND_DATA, role_q, 1'b0);
        end
        n = n + CntW'(1);
      end
      default: begin
      end
    endcase

    // Decode the byte itself when the escape did not consume it.
    if (!taken) begin
      case (in_byte_q)
        CHAR_EQUALS: begin
          if (!role_q) begin
            res[n] = mk_res(8'h00, KIND_NAME_END, 1'b0, 1'b0);
            role_d = 1'b1;
          end else begin
            res[n] = mk_res(8'h00, KIND_FIELD_END, 1'b0, 1'b0);
            role_d = 1'b0;
          end
          n = n + CntW'(1);
        end
        CHAR_AMP: begin
          res[n] = mk_res(8'h00, KIND_FIELD_END, 1'b0, 1'b0);
          role_d = 1'b0;
          n      = n + CntW'(1);
        end
        CHAR_PLUS: begin
          res[n] = mk_res(CHAR_SPACE, KIND_DATA, role_q, 1'b0);
          n      = n + CntW'(1);
        end
        CHAR_PERCENT: begin
          esc_d = ESC_PERCENT;
        end
        default: begin
          res[n] = mk_res(in_byte_q, KIND_DATA, role_q, 1'b0);
          n      = n + CntW'(1);
        end
      endcase
    end

    // The last byte flushes any open escape and closes the field.
    if (in_last_q) begin
      if (esc_d == ESC_PERCENT) begin
        res[n] = mk_res(CHAR_PERCENT, KIND_DATA, role_d, 1'b0);
        n      = n + CntW'(1);
      end else if (esc_d == ESC_DIGIT) begin
        res[n] = mk_res({4'h0, digit_d}, KIND_DATA, role_d, 1'b0);
        n      = n + CntW'(1);
      end
      res[n]  = mk_res(8'h00, KIND_FIELD_END, 1'b0, 1'b1);
      n       = n + CntW'(1);
      esc_d   = ESC_IDLE;
      digit_d = 4'h0;
      role_d  = 1'b0;
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= in_chan_i.in_byte;
      in_last_q <= in_chan_i.in_last;
    end
  end

  // Decoder state and bank fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= ESC_IDLE;
      digit_q <= 4'h0;
      role_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (proc) begin
      esc_q   <= esc_d;
      digit_q <= digit_d;
      role_q  <= role_d;
      cnt_q   <= n;
    end else if (out_fire) begin
      cnt_q   <= cnt_q - CntW'(1);
    end
  end

  // Result bank: load a fresh set, or shift towards the output on a drain.
  always_ff @(posedge clk_i) begin
    if (proc) begin
      bank_q <= res;
    end else if (out_fire) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        bank_q[i] <= bank_q[i+1];
      end
    end
  end

  assign out_chan_o.valid    = (cnt_q != '0);
  assign out_chan_o.out_byte = bank_q[0].data;
  assign out_chan_o.kind     = bank_q[0].kind;
  assign out_chan_o.in_value = bank_q[0].in_value;
  assign out_chan_o.out_last = bank_q[0].last;

  // A marker never carries a byte or a value tag.
  a_marker_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan_o.valid && out_chan_o.kind != KIND_DATA
      |-> out_chan_o.out_byte == 8'h00 && !out_chan_o.in_value)
    else $error("marker result carries data");

  // The end-of-string flag only sits on a field end.
  a_last_is_field_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan_o.valid && out_chan_o.out_last |-> out_chan_o.kind == KIND_FIELD_END)
    else $error("out_last on a result that is not a field end");

  // Finishing a string returns the decoder to its reset state.
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_last_q |=> esc_q == ESC_IDLE && !role_q && digit_q == 4'h0)
    else $error("state not cleared after last byte");

  // Every last byte yields at least its closing result.
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_last_q |=> cnt_q != '0)
    else $error("last byte produced no result");

endmodule
